FILE: src/eua_pkg.sv
// Package: operation codes, pipeline word types and sizes for the execute unit.
package eua_pkg;

    localparam int XLEN      = 32;
    localparam int PC_W      = 31;
    localparam int DIV_STEPS = XLEN;

    // Operation codes
    localparam logic [4:0] CMD_ADD   = 5'd0;
    localparam logic [4:0] CMD_SUB   = 5'd1;
    localparam logic [4:0] CMD_MUL   = 5'd2;
    localparam logic [4:0] CMD_DIV   = 5'd3;
    localparam logic [4:0] CMD_AND   = 5'd4;
    localparam logic [4:0] CMD_OR    = 5'd5;
    localparam logic [4:0] CMD_XOR   = 5'd6;
    localparam logic [4:0] CMD_NOT   = 5'd7;
    localparam logic [4:0] CMD_SLL   = 5'd8;
    localparam logic [4:0] CMD_SLA   = 5'd9;
    localparam logic [4:0] CMD_SRL   = 5'd10;
    localparam logic [4:0] CMD_SRA   = 5'd11;
    localparam logic [4:0] CMD_CMPLT = 5'd12;
    localparam logic [4:0] CMD_CMPGT = 5'd13;
    localparam logic [4:0] CMD_CMPEQ = 5'd14;
    localparam logic [4:0] CMD_ADDI  = 5'd15;
    localparam logic [4:0] CMD_SUBI  = 5'd16;
    localparam logic [4:0] CMD_MULI  = 5'd17;
    localparam logic [4:0] CMD_DIVI  = 5'd18;
    localparam logic [4:0] CMD_LOAD  = 5'd19;
    localparam logic [4:0] CMD_STORE = 5'd20;
    localparam logic [4:0] CMD_BEQ   = 5'd21;
    localparam logic [4:0] CMD_BEQI  = 5'd22;
    localparam logic [4:0] CMD_J     = 5'd23;
    localparam logic [4:0] CMD_JR    = 5'd24;
    localparam logic [4:0] CMD_JAL   = 5'd25;
    localparam logic [4:0] CMD_JALR  = 5'd26;
    localparam logic [4:0] CMD_NOP   = 5'd27;
    localparam logic [4:0] CMD_HALT  = 5'd28;

    // Which unit supplies the final result
    typedef enum logic [1:0] {
        K_ALU = 2'd0,
        K_MUL = 2'd1,
        K_DIV = 2'd2
    } t_kind;

    typedef struct packed {
        logic [4:0]      cmd;
        logic [XLEN-1:0] first_value;
        logic [XLEN-1:0] second_value;
        logic [XLEN-1:0] target_value;
        logic [XLEN-1:0] immediate;
        logic [PC_W-1:0] pc;
    } t_instr;

    // Context that travels with each word down the pipeline
    typedef struct packed {
        t_kind           kind;
        logic [XLEN-1:0] res;
        logic            wr;
        logic            wf;
        logic            ov;
        logic            dz;
        logic            neg;
        logic            br;
        logic [XLEN-1:0] npc;
        logic            rd;
        logic            wm;
        logic [XLEN-1:0] addr;
        logic [XLEN-1:0] sdata;
        logic            halt;
    } t_ctx;

    // Restoring divider working set
    typedef struct packed {
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] dvd;
        logic [XLEN-1:0] dvs;
    } t_div;

    typedef struct packed {
        logic [XLEN-1:0] result;
        logic            write_reg;
        logic [3:0]      flags;
        logic            write_flags;
        logic            branch_taken;
        logic [XLEN-1:0] next_pc;
        logic            mem_read;
        logic            mem_write;
        logic [XLEN-1:0] mem_addr;
        logic [XLEN-1:0] store_data;
        logic            finished;
    } t_res;

endpackage

FILE: src/eua_if.sv
// Interfaces: instruction, result and configuration channels.
interface eua_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  cmd;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [31:0] target_value;
    logic [31:0] immediate;
    logic [30:0] pc;
    modport source (output valid, cmd, first_value, second_value, target_value,
                    immediate, pc, input ready);
    modport sink (input valid, cmd, first_value, second_value, target_value,
                  immediate, pc, output ready);
endinterface

interface eua_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic        write_reg;
    logic [3:0]  flags;
    logic        write_flags;
    logic        branch_taken;
    logic [31:0] next_pc;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_addr;
    logic [31:0] store_data;
    logic        finished;
    modport source (output valid, result, write_reg, flags, write_flags, branch_taken,
                    next_pc, mem_read, mem_write, mem_addr, store_data, finished,
                    input ready);
    modport sink (input valid, result, write_reg, flags, write_flags, branch_taken,
                  next_pc, mem_read, mem_write, mem_addr, store_data, finished,
                  output ready);
endinterface

interface eua_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: src/eua_front.sv
// Front stage: operand select, ALU, branch, address, multiplier and divider setup.
module eua_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  eua_pkg::t_instr i_ins,
    output logic            o_vld,
    output eua_pkg::t_ctx   o_ctx,
    output logic [63:0]     o_prod,
    output eua_pkg::t_div   o_div
);
    import eua_pkg::*;

    logic            r_vld;
    t_ctx            r_ctx, n_ctx;
    logic [63:0]     r_prod, n_prod;
    t_div            r_div, n_div;
    logic [XLEN-1:0] a, b, op2, pc1;
    logic [XLEN:0]   sum, dif;
    logic [4:0]      sh;
    logic            use_imm;

    assign a       = i_ins.first_value;
    assign b       = i_ins.second_value;
    assign use_imm = (i_ins.cmd == CMD_ADDI) || (i_ins.cmd == CMD_SUBI) ||
                     (i_ins.cmd == CMD_MULI) || (i_ins.cmd == CMD_DIVI);
    assign op2     = use_imm ? i_ins.immediate : b;
    assign sum     = {a[XLEN-1], a} + {op2[XLEN-1], op2};
    assign dif     = {a[XLEN-1], a} - {op2[XLEN-1], op2};
    assign sh      = b[4:0];
    assign pc1     = {1'b0, i_ins.pc} + 32'd1;

    // Compute everything but the multiply and divide finish
    always_comb begin
        n_ctx       = '0;
        n_ctx.kind  = K_ALU;
        n_ctx.npc   = pc1;
        n_ctx.sdata = b;
        n_ctx.dz    = (op2 == '0);
        n_ctx.neg   = a[XLEN-1] ^ op2[XLEN-1];
        n_prod      = 64'($signed(a) * $signed(op2));
        n_div.rem   = '0;
        n_div.dvd   = a[XLEN-1] ? (~a + 32'd1) : a;
        n_div.dvs   = op2[XLEN-1] ? (~op2 + 32'd1) : op2;
        case (i_ins.cmd) inside
            CMD_ADD, CMD_ADDI: begin
                n_ctx.res = sum[XLEN-1:0];
                n_ctx.ov  = sum[XLEN] ^ sum[XLEN-1];
                n_ctx.wr  = 1'b1;
                n_ctx.wf  = 1'b1;
            end
            CMD_SUB, CMD_SUBI: begin
                n_ctx.res = dif[XLEN-1:0];
                n_ctx.ov  = dif[XLEN] ^ dif[XLEN-1];
                n_ctx.wr  = 1'b1;
                n_ctx.wf  = 1'b1;
            end
            CMD_MUL, CMD_MULI: begin
                n_ctx.kind = K_MUL;
                n_ctx.wr   = 1'b1;
                n_ctx.wf   = 1'b1;
            end
            CMD_DIV, CMD_DIVI: begin
                n_ctx.kind = K_DIV;
                n_ctx.wr   = 1'b1;
                n_ctx.wf   = 1'b1;
            end
            CMD_AND, CMD_OR, CMD_XOR, CMD_NOT, CMD_SLL, CMD_SLA, CMD_SRL, CMD_SRA,
            CMD_CMPLT, CMD_CMPGT, CMD_CMPEQ: begin
                n_ctx.wr = 1'b1;
                n_ctx.wf = 1'b1;
                case (i_ins.cmd)
                    CMD_AND:   n_ctx.res = a & b;
                    CMD_OR:    n_ctx.res = a | b;
                    CMD_XOR:   n_ctx.res = a ^ b;
                    CMD_NOT:   n_ctx.res = ~a;
                    CMD_SLL:   n_ctx.res = a << sh;
                    CMD_SLA: begin
                        n_ctx.res = a << sh;
                        n_ctx.ov  = a[XLEN-1] ^ n_ctx.res[XLEN-1];
                    end
                    CMD_SRL:   n_ctx.res = a >> sh;
                    CMD_SRA:   n_ctx.res = $signed(a) >>> sh;
                    CMD_CMPLT: n_ctx.res = {31'd0, $signed(a) < $signed(b)};
                    CMD_CMPGT: n_ctx.res = {31'd0, $signed(a) > $signed(b)};
                    CMD_CMPEQ: n_ctx.res = {31'd0, a == b};
                    default:   n_ctx.res = '0;
                endcase
            end
            CMD_LOAD: begin
                n_ctx.addr = a + i_ins.immediate;
                n_ctx.rd   = 1'b1;
                n_ctx.wr   = 1'b1;
            end
            CMD_STORE: begin
                n_ctx.addr = a + i_ins.immediate;
                n_ctx.wm   = 1'b1;
            end
            CMD_BEQ: begin
                if (a == b) begin
                    n_ctx.br  = 1'b1;
                    n_ctx.npc = pc1 + i_ins.immediate;
                end
            end
            CMD_BEQI: begin
                if (a == b) begin
                    n_ctx.br  = 1'b1;
                    n_ctx.npc = i_ins.target_value;
                end
            end
            CMD_J, CMD_JAL: begin
                n_ctx.br  = 1'b1;
                n_ctx.npc = pc1 + i_ins.immediate;
                if (i_ins.cmd == CMD_JAL) begin
                    n_ctx.res = pc1;
                    n_ctx.wr  = 1'b1;
                end
            end
            CMD_JR, CMD_JALR: begin
                n_ctx.br  = 1'b1;
                n_ctx.npc = a + i_ins.immediate;
                if (i_ins.cmd == CMD_JALR) begin
                    n_ctx.res = pc1;
                    n_ctx.wr  = 1'b1;
                end
            end
            CMD_HALT: begin
                n_ctx.halt = 1'b1;
                n_ctx.npc  = {1'b0, i_ins.pc};
            end
            default: begin
            end
        endcase
    end

    // Advance on enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx  <= n_ctx;
            r_prod <= n_prod;
            r_div  <= n_div;
        end
    end

    assign o_vld  = r_vld;
    assign o_ctx  = r_ctx;
    assign o_prod = r_prod;
    assign o_div  = r_div;
endmodule

FILE: src/eua_div_pipe.sv
// Divider pipeline: one restoring quotient bit per stage, context carried along.
module eua_div_pipe (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  eua_pkg::t_ctx i_ctx,
    input  eua_pkg::t_div i_div,
    output logic          o_vld,
    output eua_pkg::t_ctx o_ctx,
    output eua_pkg::t_div o_div
);
    import eua_pkg::*;

    logic r_vld [0:DIV_STEPS-1];
    t_ctx r_ctx [0:DIV_STEPS-1];
    t_div r_div [0:DIV_STEPS-1];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_step
            logic    s_vld;
            t_ctx    s_ctx;
            t_div    s_div, n_div;
            logic [XLEN:0] trial;

            if (k == 0) begin : g_first
                assign s_vld = i_vld;
                assign s_ctx = i_ctx;
                assign s_div = i_div;
            end else begin : g_next
                assign s_vld = r_vld[k-1];
                assign s_ctx = r_ctx[k-1];
                assign s_div = r_div[k-1];
            end

            // Try to subtract the divisor, shift in a quotient bit
            assign trial = {s_div.rem, s_div.dvd[XLEN-1]} - {1'b0, s_div.dvs};
            always_comb begin
                n_div.dvs = s_div.dvs;
                if (!trial[XLEN]) begin
                    n_div.rem = trial[XLEN-1:0];
                    n_div.dvd = {s_div.dvd[XLEN-2:0], 1'b1};
                end else begin
                    n_div.rem = {s_div.rem[XLEN-2:0], s_div.dvd[XLEN-1]};
                    n_div.dvd = {s_div.dvd[XLEN-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= s_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ctx[k] <= s_ctx;
                    r_div[k] <= n_div;
                end
            end
        end
    endgenerate

    assign o_vld = r_vld[DIV_STEPS-1];
    assign o_ctx = r_ctx[DIV_STEPS-1];
    assign o_div = r_div[DIV_STEPS-1];
endmodule

FILE: src/eua_back.sv
// Back stage: quotient sign fix, flag nibble, finished mark, output register.
module eua_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  eua_pkg::t_ctx           i_ctx,
    input  eua_pkg::t_div           i_div,
    input  logic [eua_pkg::PC_W-1:0] i_program_end,
    output logic                    o_vld,
    output eua_pkg::t_res           o_res
);
    import eua_pkg::*;

    logic            r_vld;
    t_res            r_res, n_res;
    logic [XLEN-1:0] res;

    // Pick the final value
    always_comb begin
        res = i_ctx.res;
        if (i_ctx.kind == K_DIV) begin
            if (i_ctx.dz) begin
                res = '0;
            end else if (i_ctx.neg) begin
                res = ~i_div.dvd + 32'd1;
            end else begin
                res = i_div.dvd;
            end
        end
    end

    always_comb begin
        n_res.result       = res;
        n_res.write_reg    = i_ctx.wr;
        n_res.write_flags  = i_ctx.wf;
        n_res.flags        = i_ctx.wf ? {i_ctx.kind == K_DIV && i_ctx.dz, i_ctx.ov,
                                         res[XLEN-1], res == '0} : 4'd0;
        n_res.branch_taken = i_ctx.br;
        n_res.next_pc      = i_ctx.npc;
        n_res.mem_read     = i_ctx.rd;
        n_res.mem_write    = i_ctx.wm;
        n_res.mem_addr     = i_ctx.addr;
        n_res.store_data   = i_ctx.sdata;
        n_res.finished     = i_ctx.halt ||
                             (!i_ctx.npc[XLEN-1] && (i_ctx.npc[PC_W-1:0] >= i_program_end));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;
endmodule

FILE: src/execute_unit_alu_branch_top.sv
// Top level: execute unit pipeline with configuration register.
//
//   channel  dir  handshake      word
//   i_in     in   valid/ready    decoded instruction
//   o_out    out  valid/ready    execute result
//   i_cfg    in   valid/ready    program_end (always ready)
//
// Stages: one front stage (ALU and multiplier), 32 divider stages
// (one quotient bit each) and one output stage. Every instruction takes the full
// depth, so results leave in order. One word enters per cycle while the output is not held.
// Reset clears all stage valid bits and program_end.
// When the output holds a word not taken, the whole pipeline holds and i_in.ready drops.
module execute_unit_alu_branch_top (
    input logic    i_clk,
    input logic    i_rst_n,
    eua_in_if.sink    i_in,
    eua_out_if.source o_out,
    eua_cfg_if.sink   i_cfg
);
    import eua_pkg::*;

    logic            en;
    logic [PC_W-1:0] r_program_end;
    t_instr          ins;
    logic            f_vld, d_vld, b_vld;
    t_ctx            f_ctx, m_ctx, d_ctx;
    logic [63:0]     f_prod;
    t_div            f_div, d_div;
    t_res            b_res;

    // Global advance whenever the output slot is free or drained
    assign en        = !b_vld || o_out.ready;
    assign i_in.ready = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_program_end <= '0;
        end else if (i_cfg.valid) begin
            r_program_end <= i_cfg.data;
        end
    end

    assign ins.cmd          = i_in.cmd;
    assign ins.first_value  = i_in.first_value;
    assign ins.second_value = i_in.second_value;
    assign ins.target_value = i_in.target_value;
    assign ins.immediate    = i_in.immediate;
    assign ins.pc           = i_in.pc;

    eua_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (i_in.valid),
        .i_ins  (ins),
        .o_vld  (f_vld),
        .o_ctx  (f_ctx),
        .o_prod (f_prod),
        .o_div  (f_div)
    );

    // Fold the registered product into the context
    always_comb begin
        m_ctx = f_ctx;
        if (f_ctx.kind == K_MUL) begin
            m_ctx.res = f_prod[XLEN-1:0];
            m_ctx.ov  = !((&f_prod[63:XLEN-1]) || !(|f_prod[63:XLEN-1]));
        end
    end

    eua_div_pipe u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (f_vld),
        .i_ctx  (m_ctx),
        .i_div  (f_div),
        .o_vld  (d_vld),
        .o_ctx  (d_ctx),
        .o_div  (d_div)
    );

    eua_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_vld        (d_vld),
        .i_ctx        (d_ctx),
        .i_div        (d_div),
        .i_program_end(r_program_end),
        .o_vld        (b_vld),
        .o_res        (b_res)
    );

    assign o_out.valid        = b_vld;
    assign o_out.result       = b_res.result;
    assign o_out.write_reg    = b_res.write_reg;
    assign o_out.flags        = b_res.flags;
    assign o_out.write_flags  = b_res.write_flags;
    assign o_out.branch_taken = b_res.branch_taken;
    assign o_out.next_pc      = b_res.next_pc;
    assign o_out.mem_read     = b_res.mem_read;
    assign o_out.mem_write    = b_res.mem_write;
    assign o_out.mem_addr     = b_res.mem_addr;
    assign o_out.store_data   = b_res.store_data;
    assign o_out.finished     = b_res.finished;

    // Checks
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");
    a_flags_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.write_flags |-> o_out.flags == 4'd0)
        else $error("flags set without write_flags");
    a_mem_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.mem_read && o_out.mem_write))
        else $error("load and store together");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input taken while output stalled");
endmodule
